[rtl/core/nvpu_pkg.sv]
// Shared types and fixed constants of the normal vector pack/unpack block.
package nvpu_pkg;

  // Restoring divider steps (quotient bits) and square root steps (root bits).
  localparam int DIV_STEPS   = 32;
  localparam int SQRT_STEPS  = 16;
  localparam int LANE_STAGES = DIV_STEPS + SQRT_STEPS;

  // One in Q2.14.
  localparam logic [15:0] Q_ONE = 16'd16384;

  // Operation codes.
  typedef enum logic {
    FUNC_PACK   = 1'b0,
    FUNC_UNPACK = 1'b1
  } func_t;

  // Per-word control that travels beside the lanes.
  typedef struct packed {
    func_t func;
    logic  zero;
    logic  neg_x;
    logic  neg_y;
  } side_t;

  // Dividend and divisor entering one lane.
  typedef struct packed {
    logic [63:0] num;
    logic [31:0] den;
  } lane_in_t;

  // Quotient, integer root of the quotient, and exactness of both.
  typedef struct packed {
    logic [31:0] quo;
    logic [15:0] root;
    logic        exact;
  } lane_out_t;

endpackage

[rtl/core/nvpu_if.sv]
// Valid/ready channel interfaces for request and response words.
interface nvpu_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] vec_x;
  logic signed [15:0] vec_y;
  logic signed [15:0] vec_z;
  logic [31:0]        packed_word;

  modport source (output valid, func, vec_x, vec_y, vec_z, packed_word, input ready);
  modport sink   (input valid, func, vec_x, vec_y, vec_z, packed_word, output ready);
endinterface

interface nvpu_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        packed_result;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [14:0]        normal_z;
  logic               zero_vector;

  modport source (output valid, packed_result, normal_x, normal_y, normal_z, zero_vector,
                  input ready);
  modport sink   (input valid, packed_result, normal_x, normal_y, normal_z, zero_vector,
                  output ready);
endinterface

[rtl/core/nvpu_prep.sv]
// Front end: squares, sums and the dividend/divisor pairs for the three lanes.
module nvpu_prep
  import nvpu_pkg::*;
#(
  parameter int CODE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  nvpu_req_if.sink req,
  output logic     valid,
  output side_t    side,
  output lane_in_t lane_x,
  output lane_in_t lane_y,
  output lane_in_t lane_z
);

  localparam logic [31:0] MAXC     = 32'((64'd1 << CODE_BITS) - 64'd1);
  localparam logic [63:0] MAXC_SQ  = {32'd0, MAXC} * {32'd0, MAXC};
  localparam logic [31:0] TWO_MAXC = MAXC << 1;

  // The whole pipeline moves together, so a word enters whenever it moves.
  // Nothing is taken while reset is held.
  assign req.ready = en && !rst;

  // Stage 1: operands and their squares.
  logic [15:0]        cx_in, cy_in;
  logic signed [17:0] op0, op1, op2;
  logic signed [35:0] pr0, pr1, pr2;
  logic [32:0]        nxu_c, nyu_c;

  assign cx_in = req.packed_word[15:0] & MAXC[15:0];
  assign cy_in = req.packed_word[31:16] & MAXC[15:0];

  always_comb begin
    if (req.func == FUNC_UNPACK) begin
      op0 = $signed({1'b0, cx_in, 1'b0}) - $signed({1'b0, MAXC[16:0]});
      op1 = $signed({1'b0, cy_in, 1'b0}) - $signed({1'b0, MAXC[16:0]});
      op2 = '0;
    end else begin
      op0 = $signed({{2{req.vec_x[15]}}, req.vec_x});
      op1 = $signed({{2{req.vec_y[15]}}, req.vec_y});
      op2 = $signed({{2{req.vec_z[15]}}, req.vec_z});
    end
  end

  assign pr0   = op0 * op0;
  assign pr1   = op1 * op1;
  assign pr2   = op2 * op2;
  assign nxu_c = {1'b0, cx_in, 16'd0} + {1'b0, MAXC};
  assign nyu_c = {1'b0, cy_in, 16'd0} + {1'b0, MAXC};

  logic        v1;
  side_t       side1;
  logic [31:0] sq0_1, sq1_1, sq2_1;
  logic [32:0] nxu1, nyu1;

  // Stage 2: length squared, scaled numerators and the z discriminant.
  logic [33:0]        sum_c;
  logic [63:0]        t0_c, t1_c;
  logic signed [34:0] d_c;

  assign sum_c = {2'b0, sq0_1} + {2'b0, sq1_1} + {2'b0, sq2_1};
  assign t0_c  = ({32'd0, sq0_1} << (2 * CODE_BITS)) - ({32'd0, sq0_1} << (CODE_BITS + 1));
  assign t1_c  = ({32'd0, sq1_1} << (2 * CODE_BITS)) - ({32'd0, sq1_1} << (CODE_BITS + 1));
  assign d_c   = $signed({3'b0, MAXC_SQ[31:0]}) - $signed({3'b0, sq0_1})
               - $signed({3'b0, sq1_1});

  logic               v2;
  side_t              side2;
  logic [31:0]        s2;
  logic [63:0]        t0_2, t1_2;
  logic [31:0]        sq0_2, sq1_2;
  logic signed [34:0] d2;
  logic [32:0]        nxu2, nyu2;

  // Stage 3: lane operands.
  logic [34:0] dabs_c;
  assign dabs_c = d2[34] ? 35'(-d2) : 35'(d2);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= req.valid;
      v2    <= v1;
      valid <= v2;
    end
  end

  // Data registers of the three stages.
  always_ff @(posedge clk) begin
    if (en) begin
      side1.func  <= func_t'(req.func);
      side1.zero  <= 1'b0;
      side1.neg_x <= req.vec_x[15];
      side1.neg_y <= req.vec_y[15];
      sq0_1       <= pr0[31:0];
      sq1_1       <= pr1[31:0];
      sq2_1       <= pr2[31:0];
      nxu1        <= nxu_c;
      nyu1        <= nyu_c;

      side2 <= side1;
      s2    <= sum_c[31:0];
      t0_2  <= t0_c;
      t1_2  <= t1_c;
      sq0_2 <= sq0_1;
      sq1_2 <= sq1_1;
      d2    <= d_c;
      nxu2  <= nxu1;
      nyu2  <= nyu1;

      side.func  <= side2.func;
      side.zero  <= (side2.func == FUNC_PACK) && (s2 == 32'd0);
      side.neg_x <= side2.neg_x;
      side.neg_y <= side2.neg_y;
      if (side2.func == FUNC_UNPACK) begin
        lane_x.num <= {31'd0, nxu2};
        lane_x.den <= TWO_MAXC;
        lane_y.num <= {31'd0, nyu2};
        lane_y.den <= TWO_MAXC;
      end else begin
        lane_x.num <= t0_2 + {32'd0, sq0_2};
        lane_x.den <= s2;
        lane_y.num <= t1_2 + {32'd0, sq1_2};
        lane_y.den <= s2;
      end
      lane_z.num <= {2'b0, dabs_c[31:0], 30'd0};
      lane_z.den <= MAXC_SQ[31:0];
    end
  end

endmodule

[rtl/core/nvpu_lane.sv]
// One lane: pipelined restoring divider followed by a pipelined integer square root.
module nvpu_lane
  import nvpu_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  lane_in_t  lin,
  output lane_out_t lout
);

  logic [31:0] rem_r [1:DIV_STEPS];
  logic [31:0] lo_r  [1:DIV_STEPS];
  logic [31:0] quo_r [1:DIV_STEPS];
  logic [31:0] den_r [1:DIV_STEPS];

  // Divider: one quotient bit per stage.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [31:0] rem_src, lo_src, quo_src, den_src;
    logic [32:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_src = lin.num[63:32];
      assign lo_src  = lin.num[31:0];
      assign quo_src = '0;
      assign den_src = lin.den;
    end else begin : g_next
      assign rem_src = rem_r[i];
      assign lo_src  = lo_r[i];
      assign quo_src = quo_r[i];
      assign den_src = den_r[i];
    end

    assign trial = {rem_src, lo_src[31]};
    assign ge    = trial >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? 32'(trial - {1'b0, den_src}) : trial[31:0];
        lo_r[i+1]  <= {lo_src[30:0], 1'b0};
        quo_r[i+1] <= {quo_src[30:0], ge};
        den_r[i+1] <= den_src;
      end
    end
  end

  logic [15:0] root_r [1:SQRT_STEPS];
  logic [19:0] rm_r   [1:SQRT_STEPS];
  logic [31:0] qs_r   [1:SQRT_STEPS];
  logic [31:0] qc_r   [1:SQRT_STEPS];
  logic        ex_r   [1:SQRT_STEPS];

  // Square root of the quotient: one root bit per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [15:0] root_src;
    logic [19:0] rm_src, rm_t, trial;
    logic [31:0] qs_src, qc_src;
    logic        ex_src, ge;

    if (j == 0) begin : g_first
      assign root_src = '0;
      assign rm_src   = '0;
      assign qs_src   = quo_r[DIV_STEPS];
      assign qc_src   = quo_r[DIV_STEPS];
      assign ex_src   = (rem_r[DIV_STEPS] == 32'd0);
    end else begin : g_next
      assign root_src = root_r[j];
      assign rm_src   = rm_r[j];
      assign qs_src   = qs_r[j];
      assign qc_src   = qc_r[j];
      assign ex_src   = ex_r[j];
    end

    assign rm_t  = {rm_src[17:0], qs_src[31:30]};
    assign trial = {2'b0, root_src, 2'b01};
    assign ge    = rm_t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rm_r[j+1]   <= ge ? (rm_t - trial) : rm_t;
        root_r[j+1] <= {root_src[14:0], ge};
        qs_r[j+1]   <= {qs_src[29:0], 2'b00};
        qc_r[j+1]   <= qc_src;
        ex_r[j+1]   <= ex_src;
      end
    end
  end

  assign lout.quo   = qc_r[SQRT_STEPS];
  assign lout.root  = root_r[SQRT_STEPS];
  assign lout.exact = ex_r[SQRT_STEPS] && (rm_r[SQRT_STEPS] == 20'd0);

endmodule

[rtl/core/nvpu_post.sv]
// Back end: turns lane results into codes or Q2.14 components and holds the output word.
module nvpu_post
  import nvpu_pkg::*;
#(
  parameter int CODE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  side_t      side,
  input  lane_out_t  lx,
  input  lane_out_t  ly,
  input  lane_out_t  lz,
  nvpu_rsp_if.source rsp
);

  localparam logic [15:0] HALF = 16'((32'd1 << (CODE_BITS - 1)));

  // The root k is floor(|comp| * M / length). A positive component takes the
  // largest even offset not above k; a negative one the smallest even offset
  // not below the exact ratio, which is k itself only when k is even and exact.
  function automatic logic [15:0] pick_code(input logic neg, input lane_out_t l);
    logic [15:0] half_k;
    logic [15:0] up;
    half_k = {1'b0, l.root[15:1]};
    up     = (l.exact && !l.root[0]) ? 16'd0 : 16'd1;
    if (neg) begin
      pick_code = HALF - half_k - up;
    end else begin
      pick_code = HALF + half_k;
    end
  endfunction

  logic [15:0] cx, cy;
  logic [16:0] zs;

  assign cx = pick_code(side.neg_x, lx);
  assign cy = pick_code(side.neg_y, ly);
  assign zs = {1'b0, lz.root} + 17'd1;

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= in_valid;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (en) begin
      if (side.func == FUNC_UNPACK) begin
        rsp.packed_result <= '0;
        rsp.normal_x      <= $signed(lx.quo[15:0] - Q_ONE);
        rsp.normal_y      <= $signed(ly.quo[15:0] - Q_ONE);
        rsp.normal_z      <= zs[15:1];
        rsp.zero_vector   <= 1'b0;
      end else begin
        rsp.packed_result <= side.zero ? 32'd0 : {cy, cx};
        rsp.normal_x      <= '0;
        rsp.normal_y      <= '0;
        rsp.normal_z      <= '0;
        rsp.zero_vector   <= side.zero;
      end
    end
  end

endmodule

[rtl/core/normal_vector_pack_unpack_top.sv]
// Top level of the surface normal pack/unpack pipeline.
// Takes one word per cycle and returns one word per request, passing it through three
// front stages (squares, sums, operand setup), 48 lane stages (a 32-step restoring
// divider and a 16-step square root, one bit per stage) and one output register. Three
// lanes run side by side: on pack they find the x and y codes, on unpack they give x, y
// and the rebuilt z. When the output word is not taken the whole pipeline holds.
module normal_vector_pack_unpack_top
  import nvpu_pkg::*;
#(
  parameter int CODE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  nvpu_req_if.sink   req,
  nvpu_rsp_if.source rsp
);

  logic en;
  assign en = !rsp.valid || rsp.ready;

  logic      p_valid;
  side_t     p_side;
  lane_in_t  lin_x, lin_y, lin_z;
  lane_out_t lout_x, lout_y, lout_z;

  nvpu_prep #(.CODE_BITS(CODE_BITS)) u_prep (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .req    (req),
    .valid  (p_valid),
    .side   (p_side),
    .lane_x (lin_x),
    .lane_y (lin_y),
    .lane_z (lin_z)
  );

  nvpu_lane u_lane_x (.clk(clk), .en(en), .lin(lin_x), .lout(lout_x));
  nvpu_lane u_lane_y (.clk(clk), .en(en), .lin(lin_y), .lout(lout_y));
  nvpu_lane u_lane_z (.clk(clk), .en(en), .lin(lin_z), .lout(lout_z));

  // Valid bits and control that keep pace with the lanes.
  logic [LANE_STAGES-1:0] vld_d;
  side_t                  side_d [LANE_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= '0;
    end else if (en) begin
      vld_d <= {vld_d[LANE_STAGES-2:0], p_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= p_side;
      for (int k = 1; k < LANE_STAGES; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  nvpu_post #(.CODE_BITS(CODE_BITS)) u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld_d[LANE_STAGES-1]),
    .side     (side_d[LANE_STAGES-1]),
    .lx       (lout_x),
    .ly       (lout_y),
    .lz       (lout_z),
    .rsp      (rsp)
  );

`ifndef NO_ASSERTIONS
  // A zero vector flag comes only with an all-zero code word and a zero normal z.
  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.zero_vector) |-> (rsp.packed_result == 32'd0 && rsp.normal_z == 15'd0))
    else $error("zero vector word carries data");

  // Rebuilt z never exceeds one.
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.normal_z <= Q_ONE[14:0]))
    else $error("normal_z out of range");

  // Unpacked x stays within minus one to one.
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.normal_x >= -16'sd16384 && rsp.normal_x <= 16'sd16384))
    else $error("normal_x out of range");

  // A word with a nonzero z came from unpack and carries no code word.
  a_op_excl: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.normal_z != 15'd0) |-> (rsp.packed_result == 32'd0))
    else $error("pack and unpack fields mixed");
`endif

endmodule
